FILE: rtl/matrix4x4_inverse_core_assert.svh
// ---------------------------------------------------------------------------
// matrix4x4_inverse_core assertion macros
// Clocked implication checks on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MATRIX4X4_INVERSE_CORE_ASSERT_SVH
`define MATRIX4X4_INVERSE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define M44I_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("m44i assertion failed");
`define M44I_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("m44i assertion failed");
`else
`define M44I_ASSERT_IMP(lbl, ante, cons)
`define M44I_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/m44i_pkg.sv
// ---------------------------------------------------------------------------
// m44i_pkg
// Widths, types and index helpers for the 4x4 fixed-point matrix inverse.
// ---------------------------------------------------------------------------
package m44i_pkg;

    localparam int ELEM_W    = 32;
    localparam int IDX_W     = 4;
    localparam int LIMB_W    = 32;
    localparam int MUL_LIMBS = 4;
    localparam int MUL_A_W   = LIMB_W * MUL_LIMBS;
    localparam int MAG_W     = LIMB_W * (MUL_LIMBS + 1);
    localparam int ACC_W     = 160;
    localparam int ADJ_W     = 100;
    localparam int DET_W     = 136;
    localparam int DEN_W     = DET_W + 1;
    localparam int NUM_W     = 160;
    localparam int Q_W       = 32;
    localparam int LCNT_W    = $clog2(MUL_LIMBS);
    localparam int DCNT_W    = $clog2(NUM_W);

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           big;
    } t_div_res;

    // column order of the six 3x3 permutation terms
    function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] j);
        logic [5:0] cols;
        begin
            case (t)
                3'd0:    cols = {2'd2, 2'd1, 2'd0};
                3'd1:    cols = {2'd1, 2'd2, 2'd0};
                3'd2:    cols = {2'd2, 2'd0, 2'd1};
                3'd3:    cols = {2'd0, 2'd2, 2'd1};
                3'd4:    cols = {2'd1, 2'd0, 2'd2};
                3'd5:    cols = {2'd0, 2'd1, 2'd2};
                default: cols = '0;
            endcase
            case (j)
                2'd0:    perm_col = cols[1:0];
                2'd1:    perm_col = cols[3:2];
                2'd2:    perm_col = cols[5:4];
                default: perm_col = 2'd0;
            endcase
        end
    endfunction

    function automatic logic perm_neg(input logic [2:0] t);
        perm_neg = (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    endfunction

    // element address of factor j of term t in the minor without row sr, col sc
    function automatic logic [IDX_W-1:0] elem_idx(input logic [1:0] sr, input logic [1:0] sc,
                                                  input logic [2:0] t, input logic [1:0] j);
        logic [1:0] pc;
        logic [1:0] row;
        logic [1:0] col;
        begin
            pc  = perm_col(t, j);
            row = (j >= sr) ? j + 2'd1 : j;
            col = (pc >= sc) ? pc + 2'd1 : pc;
            elem_idx = {row, col};
        end
    endfunction

endpackage

FILE: rtl/m44i_if.sv
// ---------------------------------------------------------------------------
// m44i request/response channels
// Valid/ready channels carrying matrix elements in and inverse elements out.
// ---------------------------------------------------------------------------
interface m44i_req_if;
    logic                              valid;
    logic                              ready;
    logic [m44i_pkg::IDX_W-1:0]        elem_index;
    logic signed [m44i_pkg::ELEM_W-1:0] elem_value;

    modport source (output valid, output elem_index, output elem_value, input ready);
    modport sink (input valid, input elem_index, input elem_value, output ready);
endinterface

interface m44i_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [m44i_pkg::IDX_W-1:0]        out_index;
    logic signed [m44i_pkg::ELEM_W-1:0] out_value;
    logic                              is_singular;
    logic                              did_saturate;
    logic                              is_last;

    modport source (output valid, output out_index, output out_value, output is_singular,
                    output did_saturate, output is_last, input ready);
    modport sink (input valid, input out_index, input out_value, input is_singular,
                  input did_saturate, input is_last, output ready);
endinterface

FILE: rtl/m44i_mul.sv
// ---------------------------------------------------------------------------
// m44i_mul
// Limb-serial unsigned multiply: 128-bit magnitude by 32 bits, one limb/cycle.
// ---------------------------------------------------------------------------
module m44i_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [m44i_pkg::MUL_A_W-1:0]  i_a,
    input  logic [m44i_pkg::LIMB_W-1:0]   i_b,
    output logic                          o_done,
    output logic [m44i_pkg::MAG_W-1:0]    o_p
);

    logic [m44i_pkg::MUL_A_W-1:0]  r_a;
    logic [m44i_pkg::LIMB_W-1:0]   r_b;
    logic [m44i_pkg::LIMB_W-1:0]   r_carry;
    logic [m44i_pkg::MAG_W-1:0]    r_p;
    logic [m44i_pkg::LCNT_W-1:0]   r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [2*m44i_pkg::LIMB_W-1:0] prod;

    assign prod = r_a[r_cnt*m44i_pkg::LIMB_W +: m44i_pkg::LIMB_W] * r_b
                + (2*m44i_pkg::LIMB_W)'(r_carry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a     <= i_a;
                r_b     <= i_b;
                r_carry <= '0;
                r_cnt   <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_p[r_cnt*m44i_pkg::LIMB_W +: m44i_pkg::LIMB_W] <= prod[m44i_pkg::LIMB_W-1:0];
                r_carry <= prod[2*m44i_pkg::LIMB_W-1:m44i_pkg::LIMB_W];
                if (r_cnt == m44i_pkg::LCNT_W'(m44i_pkg::MUL_LIMBS - 1)) begin
                    r_p[m44i_pkg::MAG_W-1 -: m44i_pkg::LIMB_W] <=
                        prod[2*m44i_pkg::LIMB_W-1:m44i_pkg::LIMB_W];
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

FILE: rtl/m44i_div.sv
// ---------------------------------------------------------------------------
// m44i_div
// Restoring bit-serial divider; keeps the low 32 quotient bits plus overflow.
// ---------------------------------------------------------------------------
module m44i_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [m44i_pkg::NUM_W-1:0]   i_num,
    input  logic [m44i_pkg::DEN_W-1:0]   i_den,
    output logic                         o_done,
    output m44i_pkg::t_div_res           o_res
);

    logic [m44i_pkg::NUM_W-1:0]  r_num;
    logic [m44i_pkg::DEN_W-1:0]  r_den;
    logic [m44i_pkg::DEN_W-1:0]  r_rem;
    logic [m44i_pkg::Q_W-1:0]    r_q;
    logic                        r_big;
    logic [m44i_pkg::DCNT_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [m44i_pkg::DEN_W:0]    trial;
    logic [m44i_pkg::DEN_W:0]    diff;
    logic                        ge;

    assign trial = {r_rem, r_num[m44i_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_big  <= 1'b0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[m44i_pkg::NUM_W-2:0], 1'b0};
                r_rem <= ge ? diff[m44i_pkg::DEN_W-1:0] : trial[m44i_pkg::DEN_W-1:0];
                r_q   <= {r_q[m44i_pkg::Q_W-2:0], ge};
                r_big <= r_big | r_q[m44i_pkg::Q_W-1];
                if (r_cnt == m44i_pkg::DCNT_W'(m44i_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_res.q   = r_q;
    assign o_res.big = r_big;

endmodule

FILE: rtl/matrix4x4_inverse_core.sv
// ---------------------------------------------------------------------------
// matrix4x4_inverse_core
// 4x4 signed fixed-point matrix inverse by cofactors and adjugate.
// ---------------------------------------------------------------------------
// Elements are loaded one per request (row-major index, Q(32-F).F). A request
// with index other than 15 only stores its element. Index 15 starts a run
// that emits 16 inverse elements; the block takes no request until the last
// one is taken. A run computes 96 cofactor terms and 4 determinant terms
// through one shared 128x32 limb-serial multiplier, then 16 divisions in a
// 160-step bit-serial divider. A zero determinant skips the divider.
`include "matrix4x4_inverse_core_assert.svh"

module matrix4x4_inverse_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    m44i_req_if.sink    i_req,
    m44i_rsp_if.source  o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE, S_LD, S_MUL, S_MW, S_ACC, S_ADJ,
        S_DL, S_DACC, S_DET, S_DIVS, S_DIVW, S_OUT
    } t_state;

    t_state                              r_state;
    logic [m44i_pkg::ELEM_W-1:0]         r_store [16];
    logic [m44i_pkg::ADJ_W-1:0]          r_adj [16];
    logic [3:0]                          r_k;
    logic [2:0]                          r_t;
    logic [1:0]                          r_j;
    logic                                r_det;
    logic                                r_psign;
    logic [m44i_pkg::MAG_W-1:0]          r_pmag;
    logic [m44i_pkg::ACC_W-1:0]          r_acc;
    logic [m44i_pkg::DET_W-1:0]          r_dmag;
    logic                                r_dsign;
    logic                                r_sing;
    logic                                r_ovalid;
    logic [m44i_pkg::IDX_W-1:0]          r_oidx;
    logic [m44i_pkg::ELEM_W-1:0]         r_oval;
    logic                                r_osing;
    logic                                r_osat;
    logic                                r_olast;

    logic [m44i_pkg::IDX_W-1:0]          rd_addr;
    logic [m44i_pkg::ELEM_W-1:0]         rd_elem;
    logic [m44i_pkg::ELEM_W-1:0]         rd_mag;
    logic [m44i_pkg::IDX_W-1:0]          adj_idx;
    logic [m44i_pkg::ADJ_W-1:0]          adj_rd;
    logic                                adj_neg;
    logic [m44i_pkg::ADJ_W-1:0]          adj_mag;
    logic                                acc_sub;
    logic [m44i_pkg::ACC_W-1:0]          acc_next;
    logic [m44i_pkg::DET_W-1:0]          det_w;
    logic                                det_neg;
    logic [m44i_pkg::DET_W-1:0]          det_mag;
    logic [m44i_pkg::NUM_W-1:0]          num;
    logic [m44i_pkg::DEN_W-1:0]          den;
    logic                                mul_done;
    logic [m44i_pkg::MAG_W-1:0]          mul_p;
    logic                                div_done;
    m44i_pkg::t_div_res                  div_res;
    logic                                out_neg;
    logic [m44i_pkg::Q_W-1:0]            lim;
    logic                                sat;
    logic [m44i_pkg::Q_W-1:0]            val;
    logic                                req_acc;

    assign req_acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // operand fetch
    assign rd_addr = r_det ? {2'b00, r_k[1:0]}
                           : m44i_pkg::elem_idx(r_k[1:0], r_k[3:2], r_t, r_j);
    assign rd_elem = r_store[rd_addr];
    assign rd_mag  = rd_elem[m44i_pkg::ELEM_W-1] ? m44i_pkg::ELEM_W'(0) - rd_elem : rd_elem;

    assign adj_idx = r_det ? {r_k[1:0], 2'b00} : r_k;
    assign adj_rd  = r_adj[adj_idx];
    assign adj_neg = adj_rd[m44i_pkg::ADJ_W-1];
    assign adj_mag = adj_neg ? m44i_pkg::ADJ_W'(0) - adj_rd : adj_rd;

    // signed accumulate of the sign-magnitude product
    assign acc_sub  = r_det ? r_psign
                            : (r_psign ^ m44i_pkg::perm_neg(r_t) ^ r_k[2] ^ r_k[0]);
    assign acc_next = acc_sub ? r_acc - r_pmag : r_acc + r_pmag;

    assign det_w   = r_acc[m44i_pkg::DET_W-1:0];
    assign det_neg = det_w[m44i_pkg::DET_W-1];
    assign det_mag = det_neg ? m44i_pkg::DET_W'(0) - det_w : det_w;

    // round to nearest: (|C| * 2^(2F+1) + |D|) / (2|D|)
    assign num = (m44i_pkg::NUM_W'(adj_mag) << (2 * FRAC_BITS + 1))
               + m44i_pkg::NUM_W'(r_dmag);
    assign den = {r_dmag, 1'b0};

    assign out_neg = adj_neg ^ r_dsign;
    assign lim     = out_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign sat     = div_res.big || (div_res.q > lim);
    assign val     = sat ? lim : (out_neg ? m44i_pkg::Q_W'(0) - div_res.q : div_res.q);

    m44i_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MUL),
        .i_a     (r_pmag[m44i_pkg::MUL_A_W-1:0]),
        .i_b     (rd_mag),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    m44i_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_DIVS) && !r_sing),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_store[i] <= '0;
            end
        end else if (req_acc) begin
            r_store[i_req.elem_index] <= i_req.elem_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADJ) begin
            r_adj[r_k] <= r_acc[m44i_pkg::ADJ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_det    <= 1'b0;
            r_k      <= '0;
            r_t      <= '0;
            r_j      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (req_acc && (i_req.elem_index == 4'd15)) begin
                        r_k     <= '0;
                        r_t     <= '0;
                        r_j     <= '0;
                        r_det   <= 1'b0;
                        r_acc   <= '0;
                        r_state <= S_LD;
                    end
                end
                S_LD: begin
                    r_pmag  <= m44i_pkg::MAG_W'(rd_mag);
                    r_psign <= rd_elem[m44i_pkg::ELEM_W-1];
                    r_j     <= 2'd1;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_psign <= r_psign ^ rd_elem[m44i_pkg::ELEM_W-1];
                    r_state <= S_MW;
                end
                S_MW: begin
                    if (mul_done) begin
                        r_pmag <= mul_p;
                        if (r_det) begin
                            r_state <= S_DACC;
                        end else if (r_j == 2'd1) begin
                            r_j     <= 2'd2;
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    r_acc <= acc_next;
                    if (r_t == 3'd5) begin
                        r_state <= S_ADJ;
                    end else begin
                        r_t     <= r_t + 1'b1;
                        r_j     <= '0;
                        r_state <= S_LD;
                    end
                end
                S_ADJ: begin
                    r_acc <= '0;
                    r_t   <= '0;
                    r_j   <= '0;
                    if (r_k == 4'd15) begin
                        r_k     <= '0;
                        r_det   <= 1'b1;
                        r_state <= S_DL;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_LD;
                    end
                end
                S_DL: begin
                    r_pmag  <= m44i_pkg::MAG_W'(adj_mag);
                    r_psign <= adj_neg;
                    r_state <= S_MUL;
                end
                S_DACC: begin
                    r_acc <= acc_next;
                    if (r_k == 4'd3) begin
                        r_state <= S_DET;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_DL;
                    end
                end
                S_DET: begin
                    r_dmag  <= det_mag;
                    r_dsign <= det_neg;
                    r_sing  <= (det_w == '0);
                    r_det   <= 1'b0;
                    r_k     <= '0;
                    r_state <= S_DIVS;
                end
                S_DIVS: begin
                    if (r_sing) begin
                        r_ovalid <= 1'b1;
                        r_oidx   <= r_k;
                        r_oval   <= '0;
                        r_osing  <= 1'b1;
                        r_osat   <= 1'b0;
                        r_olast  <= (r_k == 4'd15);
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_ovalid <= 1'b1;
                        r_oidx   <= r_k;
                        r_oval   <= val;
                        r_osing  <= 1'b0;
                        r_osat   <= sat;
                        r_olast  <= (r_k == 4'd15);
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_ovalid <= 1'b0;
                        if (r_k == 4'd15) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_DIVS;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.out_index    = r_oidx;
    assign o_rsp.out_value    = r_oval;
    assign o_rsp.is_singular  = r_osing;
    assign o_rsp.did_saturate = r_osat;
    assign o_rsp.is_last      = r_olast;

    `M44I_ASSERT_IMP(a_ready_no_rsp, i_req.ready, !o_rsp.valid)
    `M44I_ASSERT_IMP(a_sing_zero, o_rsp.valid && o_rsp.is_singular, (o_rsp.out_value == '0) && !o_rsp.did_saturate)
    `M44I_ASSERT_NXT(a_last_idle, o_rsp.valid && o_rsp.ready && o_rsp.is_last, i_req.ready)

endmodule
